### sv/polygon_fan_triangulator_top_macros.svh
// Assertion macros shared by the polygon fan triangulator RTL.
`ifndef POLYGON_FAN_TRIANGULATOR_TOP_MACROS_SVH
`define POLYGON_FAN_TRIANGULATOR_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define PFT_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true outside reset.
`define PFT_NEVER(name, clk, rst_n, expr, msg) \
  `PFT_ASSERT(name, clk, rst_n, !(expr), msg)
`else
`define PFT_ASSERT(name, clk, rst_n, prop, msg)
`define PFT_NEVER(name, clk, rst_n, expr, msg)
`endif

`endif

### sv/pft_pkg.sv
// Shared types and constants of the polygon fan triangulator.
package pft_pkg;

  // Kind of triangle run that one corner beat produces.
  typedef enum logic [3:0] {
    CMD_FAN1 = 4'b0001,  // one fan triangle (0, previous, current)
    CMD_FAN3 = 4'b0010,  // fifth corner: three fan triangles
    CMD_TRI  = 4'b0100,  // triangle polygon gives itself
    CMD_QUAD = 4'b1000   // quad split along the shorter diagonal
  } cmd_kind_t;

  // Control word that travels from the front end to the emitter.
  typedef struct packed {
    cmd_kind_t kind;
    logic      use02;  // quad: split along the 0-2 diagonal
  } tri_ctl_t;

  // Corner count values.
  localparam logic [2:0] COUNT_TRI  = 3'd2;
  localparam logic [2:0] COUNT_QUAD = 3'd3;
  localparam logic [2:0] COUNT_FAN  = 3'd4;
  localparam logic [2:0] COUNT_SAT  = 3'd5;

  // Positions of the corner indices carried with each command.
  localparam int unsigned POS_C0  = 0;
  localparam int unsigned POS_C1  = 1;
  localparam int unsigned POS_C2  = 2;
  localparam int unsigned POS_C3  = 3;
  localparam int unsigned POS_CUR = 4;
  localparam int unsigned NUM_POS = 5;

  // Depth of the command queue between front end and emitter.
  localparam int unsigned QUEUE_DEPTH = 8;

  // Number of triangles a command emits.
  function automatic logic [1:0] cmd_steps(input cmd_kind_t kind);
    logic [1:0] n;
    case (kind)
      CMD_FAN3: n = 2'd3;
      CMD_QUAD: n = 2'd2;
      default:  n = 2'd1;
    endcase
    return n;
  endfunction

endpackage

### sv/pft_if.sv
// Valid/ready channel interfaces for corner beats and triangle beats.
interface pft_in_if #(
  parameter int unsigned INDEX_BITS = 20,
  parameter int unsigned COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic        [INDEX_BITS-1:0] vertex_index;
  logic signed [COORD_BITS-1:0] x_coord;
  logic signed [COORD_BITS-1:0] y_coord;
  logic signed [COORD_BITS-1:0] z_coord;
  logic                         polygon_end;

  modport source (output valid, vertex_index, x_coord, y_coord, z_coord, polygon_end,
                  input ready);
  modport sink   (input valid, vertex_index, x_coord, y_coord, z_coord, polygon_end,
                  output ready);
endinterface

interface pft_out_if #(
  parameter int unsigned INDEX_BITS = 20
);
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] corner_a;
  logic [INDEX_BITS-1:0] corner_b;
  logic [INDEX_BITS-1:0] corner_c;
  logic                  run_end;

  modport source (output valid, corner_a, corner_b, corner_c, run_end, input ready);
  modport sink   (input valid, corner_a, corner_b, corner_c, run_end, output ready);
endinterface

### sv/polygon_fan_triangulator_top.sv
// Top level of the polygon fan triangulator.
// Path: a corner beat passes the difference, square and sum registers, the command
// queue and the output register before its first triangle is shown.
// Throughput: one corner beat per cycle while the queue has room; the emitter gives
// one triangle beat per cycle while out_ch.ready is high; three for the fifth corner.
// Reset: synchronous active-low rst_n clears the corner count, queue and valid bits.
module polygon_fan_triangulator_top #(
  parameter int unsigned INDEX_BITS = 20,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  pft_in_if.sink    in_ch,
  pft_out_if.source out_ch
);
  import pft_pkg::*;

  localparam int unsigned QW = $bits(tri_ctl_t) + NUM_POS * INDEX_BITS;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH+1);

  logic                               push;
  tri_ctl_t                           push_ctl;
  logic [NUM_POS-1:0][INDEX_BITS-1:0] push_idx;
  logic                               pop;
  logic                               head_valid;
  logic [QW-1:0]                      head_data;
  tri_ctl_t                           head_ctl;
  logic [NUM_POS-1:0][INDEX_BITS-1:0] head_idx;
  logic [CW-1:0]                      q_count;

  // Corner intake, polygon tracking and quad diagonal choice.
  pft_front #(
    .INDEX_BITS  (INDEX_BITS),
    .COORD_BITS  (COORD_BITS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_count  (q_count),
    .push     (push),
    .push_ctl (push_ctl),
    .push_idx (push_idx)
  );

  // Command queue.
  pft_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  ({push_ctl, push_idx}),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data),
    .count      (q_count)
  );

  assign {head_ctl, head_idx} = head_data;

  // Triangle emitter.
  pft_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_ctl   (head_ctl),
    .head_idx   (head_idx),
    .pop        (pop),
    .out_ch     (out_ch)
  );
endmodule

### sv/pft_queue.sv
// Small register queue that decouples the front end from the emitter.
`include "polygon_fan_triangulator_top_macros.svh"
module pft_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic                       head_valid,
  output logic [WIDTH-1:0]           head_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH+1);
  localparam logic [CW-1:0] FullCount = CW'(DEPTH);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  // Pointer and occupancy bookkeeping.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_valid = (count_r != '0);
  assign head_data  = entry_r[rd_ptr_r];
  assign count      = count_r;

  `PFT_NEVER(a_queue_overflow, clk, rst_n, push && count_r == FullCount,
             "command pushed into a full queue")
  `PFT_NEVER(a_queue_underflow, clk, rst_n, pop && count_r == '0,
             "command popped from an empty queue")
endmodule

### sv/pft_front.sv
// Front end: takes corner beats, tracks the polygon and classifies commands.
`include "polygon_fan_triangulator_top_macros.svh"
module pft_front #(
  parameter int unsigned INDEX_BITS  = 20,
  parameter int unsigned COORD_BITS  = 16,
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  pft_in_if.sink                                            in_ch,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]                  q_count,
  output logic                                              push,
  output pft_pkg::tri_ctl_t                                 push_ctl,
  output logic [pft_pkg::NUM_POS-1:0][INDEX_BITS-1:0]       push_idx
);
  import pft_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned SQW = 2 * CB;
  localparam int unsigned SUMW = 2 * CB + 2;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH+1);
  localparam logic [CW:0] DepthW = (CW+1)'(QUEUE_DEPTH);

  // Absolute difference of two signed coordinates; always fits CB bits.
  function automatic logic [CB-1:0] absd(input logic signed [CB-1:0] p,
                                         input logic signed [CB-1:0] q);
    logic signed [CB:0] d;
    d = {p[CB-1], p} - {q[CB-1], q};
    return d[CB] ? CB'(-d) : d[CB-1:0];
  endfunction

  // Polygon state.
  logic        [INDEX_BITS-1:0] hidx_r [4];
  logic signed [CB-1:0]         hx_r   [3];
  logic signed [CB-1:0]         hy_r   [3];
  logic signed [CB-1:0]         hz_r   [3];
  logic        [2:0]            count_r, count_nxt;

  // Distance pipeline: differences, squares, sums.
  logic                                  s1_v_r, s2_v_r, s3_v_r;
  cmd_kind_t                             s1_kind_r, s2_kind_r, s3_kind_r;
  logic [NUM_POS-1:0][INDEX_BITS-1:0]    s1_idx_r, s2_idx_r, s3_idx_r;
  logic [2:0][CB-1:0]                    s1_d02_r, s1_d13_r;
  logic [2:0][SQW-1:0]                   s2_q02_r, s2_q13_r;
  logic [SUMW-1:0]                       s3_sum02_r, s3_sum13_r;

  logic                               accept;
  logic                               last;
  logic                               has_cmd;
  cmd_kind_t                          kind;
  logic [1:0]                         slot;
  logic [1:0]                         inflight;
  logic [CW:0]                        occupancy;
  logic [NUM_POS-1:0][INDEX_BITS-1:0] snap_idx;
  logic [2:0][CB-1:0]                 d02, d13;

  // Space check: queue entries plus commands still in the distance pipeline.
  assign inflight  = 2'(s1_v_r) + 2'(s2_v_r) + 2'(s3_v_r);
  assign occupancy = {1'b0, q_count} + (CW+1)'(inflight);
  assign in_ch.ready = (occupancy < DepthW);
  assign accept = in_ch.valid && in_ch.ready;
  assign last   = in_ch.polygon_end;

  // Classify the beat from the corner count before it.
  always_comb begin
    has_cmd = 1'b0;
    kind    = CMD_FAN1;
    if (count_r >= COUNT_SAT) begin
      has_cmd = 1'b1;
      kind    = CMD_FAN1;
    end else if (count_r == COUNT_FAN) begin
      has_cmd = 1'b1;
      kind    = CMD_FAN3;
    end else if (last && count_r == COUNT_TRI) begin
      has_cmd = 1'b1;
      kind    = CMD_TRI;
    end else if (last && count_r == COUNT_QUAD) begin
      has_cmd = 1'b1;
      kind    = CMD_QUAD;
    end
  end

  // Snapshot of the held corners before this beat writes its slot, and diagonal differences.
  always_comb begin
    snap_idx[POS_C0]  = hidx_r[0];
    snap_idx[POS_C1]  = hidx_r[1];
    snap_idx[POS_C2]  = hidx_r[2];
    snap_idx[POS_C3]  = hidx_r[3];
    snap_idx[POS_CUR] = in_ch.vertex_index;
    d02[0] = absd(hx_r[0], hx_r[2]);
    d02[1] = absd(hy_r[0], hy_r[2]);
    d02[2] = absd(hz_r[0], hz_r[2]);
    d13[0] = absd(hx_r[1], in_ch.x_coord);
    d13[1] = absd(hy_r[1], in_ch.y_coord);
    d13[2] = absd(hz_r[1], in_ch.z_coord);
  end

  // Slot to write and next corner count.
  always_comb begin
    slot      = (count_r < 3'd4) ? count_r[1:0] : 2'd3;
    count_nxt = count_r;
    if (last) begin
      count_nxt = '0;
    end else if (count_r >= COUNT_SAT) begin
      count_nxt = COUNT_SAT;
    end else begin
      count_nxt = count_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  // Held corners; coordinates are only needed for the first three.
  always_ff @(posedge clk) begin
    if (accept) begin
      hidx_r[slot] <= in_ch.vertex_index;
      if (slot != 2'd3) begin
        hx_r[slot] <= in_ch.x_coord;
        hy_r[slot] <= in_ch.y_coord;
        hz_r[slot] <= in_ch.z_coord;
      end
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept && has_cmd;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // Pipeline payload: differences, then squares, then sums.
  always_ff @(posedge clk) begin
    s1_kind_r <= kind;
    s1_idx_r  <= snap_idx;
    s1_d02_r  <= d02;
    s1_d13_r  <= d13;
    s2_kind_r <= s1_kind_r;
    s2_idx_r  <= s1_idx_r;
    for (int i = 0; i < 3; i++) begin
      s2_q02_r[i] <= SQW'(s1_d02_r[i]) * SQW'(s1_d02_r[i]);
      s2_q13_r[i] <= SQW'(s1_d13_r[i]) * SQW'(s1_d13_r[i]);
    end
    s3_kind_r  <= s2_kind_r;
    s3_idx_r   <= s2_idx_r;
    s3_sum02_r <= SUMW'(s2_q02_r[0]) + SUMW'(s2_q02_r[1]) + SUMW'(s2_q02_r[2]);
    s3_sum13_r <= SUMW'(s2_q13_r[0]) + SUMW'(s2_q13_r[1]) + SUMW'(s2_q13_r[2]);
  end

  // Final compare picks the quad diagonal; ties go to 1-3.
  assign push           = s3_v_r;
  assign push_ctl.kind  = s3_kind_r;
  assign push_ctl.use02 = (s3_sum02_r < s3_sum13_r);
  assign push_idx       = s3_idx_r;

  `PFT_NEVER(a_front_credit, clk, rst_n, occupancy > DepthW,
             "queue plus pipeline commands exceed queue depth")
endmodule

### sv/pft_back.sv
// Emitter: walks each queued command and drives one triangle beat per cycle unless stalled.
`include "polygon_fan_triangulator_top_macros.svh"
module pft_back #(
  parameter int unsigned INDEX_BITS = 20
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        head_valid,
  input  pft_pkg::tri_ctl_t                           head_ctl,
  input  logic [pft_pkg::NUM_POS-1:0][INDEX_BITS-1:0] head_idx,
  output logic                                        pop,
  pft_out_if.source                                   out_ch
);
  import pft_pkg::*;

  logic [1:0]            step_r, step_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [INDEX_BITS-1:0] a_r, b_r, c_r;
  logic                  end_r;

  logic [1:0]            nsteps;
  logic                  last_step;
  logic                  load;
  logic [INDEX_BITS-1:0] tri_a, tri_b, tri_c;
  logic [INDEX_BITS-1:0] h0, h1, h2, h3, cur;

  assign h0  = head_idx[POS_C0];
  assign h1  = head_idx[POS_C1];
  assign h2  = head_idx[POS_C2];
  assign h3  = head_idx[POS_C3];
  assign cur = head_idx[POS_CUR];

  assign nsteps    = cmd_steps(head_ctl.kind);
  assign last_step = (step_r == nsteps - 2'd1);
  assign load      = head_valid && (!out_valid_r || out_ch.ready);
  assign pop       = load && last_step;

  // Triangle for the current step of the head command.
  always_comb begin
    tri_a = h0;
    tri_b = h3;
    tri_c = cur;
    unique case (head_ctl.kind)
      CMD_FAN1: begin
        tri_a = h0;
        tri_b = h3;
        tri_c = cur;
      end
      CMD_FAN3: begin
        tri_a = h0;
        case (step_r)
          2'd0: begin
            tri_b = h1;
            tri_c = h2;
          end
          2'd1: begin
            tri_b = h2;
            tri_c = h3;
          end
          default: begin
            tri_b = h3;
            tri_c = cur;
          end
        endcase
      end
      CMD_TRI: begin
        tri_a = h0;
        tri_b = h1;
        tri_c = cur;
      end
      CMD_QUAD: begin
        if (head_ctl.use02) begin
          tri_a = h0;
          tri_b = step_r == 2'd0 ? h1 : h2;
          tri_c = step_r == 2'd0 ? h2 : cur;
        end else begin
          tri_a = h1;
          tri_b = step_r == 2'd0 ? h2 : cur;
          tri_c = step_r == 2'd0 ? cur : h0;
        end
      end
      default: begin
        tri_a = h0;
        tri_b = h3;
        tri_c = cur;
      end
    endcase
  end

  // Step counter and output register occupancy.
  always_comb begin
    step_nxt = step_r;
    if (load) begin
      step_nxt = last_step ? 2'd0 : step_r + 2'd1;
    end
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output beat payload.
  always_ff @(posedge clk) begin
    if (load) begin
      a_r   <= tri_a;
      b_r   <= tri_b;
      c_r   <= tri_c;
      end_r <= last_step;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.corner_a = a_r;
  assign out_ch.corner_b = b_r;
  assign out_ch.corner_c = c_r;
  assign out_ch.run_end  = end_r;

  `PFT_NEVER(a_back_step_range, clk, rst_n, head_valid && step_r >= nsteps,
             "emitter step counter past the end of its command")
endmodule
